/* rtl/lrs_pkg.sv */
// Shared constants for the learning rate schedule block: register indexes,
// schedule and phase codes, reset values and the cosine series tables.
// No dependencies.
package lrs_pkg;

	localparam int EPOCH_BITS_DEF     = 16;
	localparam int RATE_FRAC_BITS_DEF = 24;

	// register indexes on the configuration port
	localparam logic [2:0] REG_INITIAL = 3'd0;
	localparam logic [2:0] REG_FLOOR   = 3'd1;
	localparam logic [2:0] REG_DECAY   = 3'd2;
	localparam logic [2:0] REG_PERIOD  = 3'd3;
	localparam logic [2:0] REG_WARMUP  = 3'd4;
	localparam logic [2:0] REG_KIND    = 3'd5;

	// schedule kinds
	localparam logic [1:0] KIND_STEP      = 2'd0;
	localparam logic [1:0] KIND_MULTISTEP = 2'd1;
	localparam logic [1:0] KIND_COSINE    = 2'd2;
	localparam logic [1:0] KIND_CONSTANT  = 2'd3;

	// phase codes on the result
	localparam logic [1:0] PHASE_WARMUP   = 2'd0;
	localparam logic [1:0] PHASE_STEP     = 2'd1;
	localparam logic [1:0] PHASE_COSINE   = 2'd2;
	localparam logic [1:0] PHASE_CONSTANT = 2'd3;

	// register reset values
	localparam logic [31:0] RST_INITIAL = 32'd167772;
	localparam logic [31:0] RST_FLOOR   = 32'd0;
	localparam logic [24:0] RST_DECAY   = 25'd1677722;
	localparam logic [15:0] RST_PERIOD  = 16'd30;
	localparam logic [15:0] RST_WARMUP  = 16'd0;
	localparam logic [1:0]  RST_KIND    = KIND_STEP;

	// cosine evaluation, Q30 fixed point
	localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
	localparam logic [30:0] PI_Q29     = 31'd1686629713;
	localparam int          TURN_NUM_W = 48;  // 17-bit residue shifted up by 31
	localparam int          HORNER_STEPS = 6;

	localparam logic [7:0] HORNER_DIV [HORNER_STEPS] = '{
		8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
	};

	// floor(2^32 / divisor), off by at most one after the multiply
	localparam logic [31:0] HORNER_RECIP [HORNER_STEPS] = '{
		32'(64'd4294967296 / 64'd132),
		32'(64'd4294967296 / 64'd90),
		32'(64'd4294967296 / 64'd56),
		32'(64'd4294967296 / 64'd30),
		32'(64'd4294967296 / 64'd12),
		32'(64'd4294967296 / 64'd2)
	};

endpackage

/* rtl/lrs_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// A new request every cycle. No dependencies.
module lrs_div #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W-1];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W-1:0] r_in;
		logic [NUM_W-1:0] n_in;
		logic [DEN_W-1:0] d_in;
		logic [DEN_W:0]   t;
		logic             ge;

		if (i == 0) begin : g_first
			assign r_in = '0;
			assign n_in = num;
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_s[i-1];
			assign n_in = nq_s[i-1];
			assign d_in = den_s[i-1];
		end

		// shift in the next numerator bit, subtract when it fits
		assign t  = {r_in, n_in[NUM_W-1]};
		assign ge = (t >= {1'b0, d_in});

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? DEN_W'(t - {1'b0, d_in}) : t[DEN_W-1:0];
			nq_s[i]  <= {n_in[NUM_W-2:0], ge};
		end

		if (i < NUM_W - 1) begin : g_den
			always_ff @(posedge clk) begin
				den_s[i] <= d_in;
			end
		end
	end

	assign quo = nq_s[NUM_W-1];
	assign rem = rem_s[NUM_W-1];

endmodule

/* rtl/lrs_delay.sv */
// Fixed delay line of N register stages, cleared by reset.
// Aligns side paths of the schedule pipeline. No dependencies.
module lrs_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_s [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				tap_s[i] <= '0;
			end
		end else begin
			tap_s[0] <= d;
			for (int i = 1; i < N; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[N-1];

endmodule

/* rtl/learning_rate_schedule_core.sv */
// Learning rate schedule evaluator: one epoch request per cycle, one result each.
// The result path runs through the chained epoch/period and turn dividers and
// the cosine series stages. Throughput: one request every cycle; busy stays low.
// Reset clears the registers to their defaults and empties the pipeline.
// Uses lrs_pkg, lrs_div and lrs_delay.
module learning_rate_schedule_core #(
	parameter int EPOCH_BITS     = lrs_pkg::EPOCH_BITS_DEF,
	parameter int RATE_FRAC_BITS = lrs_pkg::RATE_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [EPOCH_BITS-1:0] epoch_index,
	output logic                  done,
	output logic [31:0]           learning_rate,
	output logic [1:0]            phase,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	localparam int EXT_W    = (EPOCH_BITS > 16) ? EPOCH_BITS : 16;
	localparam int WNUM_W   = 33 + EPOCH_BITS;
	localparam int DW       = RATE_FRAC_BITS + 1;
	localparam int NH       = lrs_pkg::HORNER_STEPS;
	localparam int LAT_WARM = WNUM_W;
	localparam int LAT_STEP = 2 * EPOCH_BITS + 1;
	localparam int LAT_COS  = EPOCH_BITS + lrs_pkg::TURN_NUM_W + 5 + 3 * NH;
	localparam int D_WARM   = LAT_COS - LAT_WARM;
	localparam int D_STEP   = LAT_COS - LAT_STEP;

	// configuration registers
	logic [31:0] init_q;
	logic [31:0] floor_q;
	logic [24:0] decay_q;
	logic [15:0] period_q;
	logic [15:0] warmup_q;
	logic [1:0]  kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q   <= lrs_pkg::RST_INITIAL;
			floor_q  <= lrs_pkg::RST_FLOOR;
			decay_q  <= lrs_pkg::RST_DECAY;
			period_q <= lrs_pkg::RST_PERIOD;
			warmup_q <= lrs_pkg::RST_WARMUP;
			kind_q   <= lrs_pkg::RST_KIND;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lrs_pkg::REG_INITIAL: init_q   <= cfg_data;
				lrs_pkg::REG_FLOOR:   floor_q  <= cfg_data;
				lrs_pkg::REG_DECAY:   decay_q  <= cfg_data[24:0];
				lrs_pkg::REG_PERIOD:  period_q <= cfg_data[15:0];
				lrs_pkg::REG_WARMUP:  warmup_q <= cfg_data[15:0];
				lrs_pkg::REG_KIND:    kind_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// values derived from the registers; the user must keep them static while requests are in flight, not enforced here
	logic          diff_neg;
	logic [31:0]   abs_diff;
	logic [15:0]   period_eff;
	logic [DW-1:0] one_fx;
	logic [DW-1:0] decay_sat;

	assign diff_neg   = (init_q < floor_q);
	assign abs_diff   = diff_neg ? (floor_q - init_q) : (init_q - floor_q);
	assign period_eff = (period_q == 16'd0) ? 16'd1 : period_q;
	assign one_fx     = DW'(1) << RATE_FRAC_BITS;
	assign decay_sat  = ({7'd0, decay_q} > (32'd1 << RATE_FRAC_BITS)) ? one_fx : DW'(decay_q);

	// stage 1: input register
	logic                  vld_s1;
	logic [EPOCH_BITS-1:0] epoch_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		epoch_s1 <= epoch_index;
	end

	// stage 2: warmup test, effective epoch, warmup numerator
	logic                  warm_c;
	logic [EPOCH_BITS-1:0] e_c;
	logic [EPOCH_BITS:0]   ep1_c;
	logic                  vld_s2;
	logic                  warm_s2;
	logic [EPOCH_BITS-1:0] e_s2;
	logic [WNUM_W-1:0]     absnum_s2;

	assign warm_c = (warmup_q != 16'd0) && (EXT_W'(epoch_s1) < EXT_W'(warmup_q));
	assign e_c    = EPOCH_BITS'(EXT_W'(epoch_s1) - EXT_W'(warmup_q));
	assign ep1_c  = {1'b0, epoch_s1} + (EPOCH_BITS+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			warm_s2 <= 1'b0;
		end else begin
			vld_s2  <= vld_s1;
			warm_s2 <= warm_c;
		end
	end

	always_ff @(posedge clk) begin
		e_s2      <= e_c;
		absnum_s2 <= WNUM_W'(abs_diff) * WNUM_W'(ep1_c);
	end

	// warmup quotient |diff|*(epoch+1)/warmup
	logic [WNUM_W-1:0] wquo;

	lrs_div #(.NUM_W(WNUM_W), .DEN_W(16)) u_wdiv (
		.clk (clk),
		.num (absnum_s2),
		.den (warmup_q),
		.quo (wquo),
		.rem ()
	);

	// decay step count and remainder within the period
	logic [EPOCH_BITS-1:0] kquo;
	logic [15:0]           krem;

	lrs_div #(.NUM_W(EPOCH_BITS), .DEN_W(16)) u_kdiv (
		.clk (clk),
		.num (e_s2),
		.den (period_eff),
		.quo (kquo),
		.rem (krem)
	);

	// position in the cosine cycle: residue mod 2*period, as a turn fraction
	logic [16:0]                     resid;
	logic [lrs_pkg::TURN_NUM_W-1:0] tquo;

	assign resid = 17'(krem) + (kquo[0] ? 17'(period_eff) : 17'd0);

	lrs_div #(.NUM_W(lrs_pkg::TURN_NUM_W), .DEN_W(16)) u_tdiv (
		.clk (clk),
		.num ({resid, 31'd0}),
		.den (period_eff),
		.quo (tquo),
		.rem ()
	);

	// decay power by square and multiply, one exponent bit per stage
	logic [DW-1:0]         pw_p_s [EPOCH_BITS];
	logic [DW-1:0]         pw_d_s [EPOCH_BITS-1];
	logic [EPOCH_BITS-1:0] pw_k_s [EPOCH_BITS-1];

	for (genvar j = 0; j < EPOCH_BITS; j++) begin : g_pow
		logic [DW-1:0]         p_in;
		logic [DW-1:0]         d_in;
		logic [EPOCH_BITS-1:0] k_in;
		logic [2*DW-1:0]       pd;
		logic [2*DW-1:0]       dd;

		if (j == 0) begin : g_first
			assign p_in = one_fx;
			assign d_in = decay_sat;
			assign k_in = kquo;
		end else begin : g_next
			assign p_in = pw_p_s[j-1];
			assign d_in = pw_d_s[j-1];
			assign k_in = pw_k_s[j-1];
		end

		assign pd = (2*DW)'(p_in) * (2*DW)'(d_in) + ((2*DW)'(1) << (RATE_FRAC_BITS - 1));
		assign dd = (2*DW)'(d_in) * (2*DW)'(d_in) + ((2*DW)'(1) << (RATE_FRAC_BITS - 1));

		always_ff @(posedge clk) begin
			pw_p_s[j] <= k_in[j] ? DW'(pd >> RATE_FRAC_BITS) : p_in;
		end

		if (j < EPOCH_BITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				pw_d_s[j] <= DW'(dd >> RATE_FRAC_BITS);
				pw_k_s[j] <= k_in;
			end
		end
	end

	logic [31+DW:0] step_prod;
	logic [31:0]    step_s;

	assign step_prod = (32+DW)'(init_q) * (32+DW)'(pw_p_s[EPOCH_BITS-1])
		+ ((32+DW)'(1) << (RATE_FRAC_BITS - 1));

	always_ff @(posedge clk) begin
		step_s <= 32'(step_prod >> RATE_FRAC_BITS);
	end

	// fold the turn into a quarter turn, note the sign of the cosine
	logic [31:0] turn;
	logic [31:0] half_fold;
	logic        fold_gt;
	logic [30:0] fold_s;
	logic        neg_f_s;

	assign turn      = tquo[31:0];
	assign half_fold = turn[31] ? 32'((33'd1 << 32) - 33'(turn)) : turn;
	assign fold_gt   = (half_fold > 32'h4000_0000);

	always_ff @(posedge clk) begin
		fold_s  <= fold_gt ? 31'(32'h8000_0000 - half_fold) : 31'(half_fold);
		neg_f_s <= fold_gt;
	end

	// angle in Q2.30 and its square
	logic [31:0] x_s;
	logic        neg_x_s;
	logic [31:0] x2_s;
	logic        neg_x2_s;

	always_ff @(posedge clk) begin
		x_s      <= 32'((62'(fold_s) * 62'(lrs_pkg::PI_Q29)) >> 30);
		neg_x_s  <= neg_f_s;
		x2_s     <= 32'((64'(x_s) * 64'(x_s)) >> 30);
		neg_x2_s <= neg_x_s;
	end

	// Horner steps t = 1 - x2*t/div, three stages each: multiply,
	// reciprocal multiply, correct and subtract
	logic [31:0] hp_s   [NH];
	logic [31:0] h_pb_s [NH];
	logic [31:0] hq_s   [NH];
	logic [30:0] ht_s   [NH];
	logic [31:0] h_x2a_s [NH];
	logic [31:0] h_x2b_s [NH];
	logic [31:0] h_x2c_s [NH-1];
	logic        h_na_s [NH];
	logic        h_nb_s [NH];
	logic        h_nc_s [NH];

	for (genvar i = 0; i < NH; i++) begin : g_horner
		logic [31:0] x2_in;
		logic [30:0] t_in;
		logic        n_in;
		logic [31:0] rem_c;
		logic [31:0] q_c;

		if (i == 0) begin : g_first
			assign x2_in = x2_s;
			assign t_in  = lrs_pkg::Q30_ONE;
			assign n_in  = neg_x2_s;
		end else begin : g_next
			assign x2_in = h_x2c_s[i-1];
			assign t_in  = ht_s[i-1];
			assign n_in  = h_nc_s[i-1];
		end

		assign rem_c = h_pb_s[i] - 32'(40'(hq_s[i]) * 40'(lrs_pkg::HORNER_DIV[i]));
		assign q_c   = (rem_c >= 32'(lrs_pkg::HORNER_DIV[i])) ? hq_s[i] + 32'd1 : hq_s[i];

		always_ff @(posedge clk) begin
			hp_s[i]    <= 32'((63'(x2_in) * 63'(t_in)) >> 30);
			h_x2a_s[i] <= x2_in;
			h_na_s[i]  <= n_in;

			hq_s[i]    <= 32'((64'(hp_s[i]) * 64'(lrs_pkg::HORNER_RECIP[i])) >> 32);
			h_pb_s[i]  <= hp_s[i];
			h_x2b_s[i] <= h_x2a_s[i];
			h_nb_s[i]  <= h_na_s[i];

			// clamp a negative term to zero
			ht_s[i]    <= (q_c > 32'(lrs_pkg::Q30_ONE)) ? 31'd0 : 31'(32'(lrs_pkg::Q30_ONE) - q_c);
			h_nc_s[i]  <= h_nb_s[i];
		end

		if (i < NH - 1) begin : g_carry
			always_ff @(posedge clk) begin
				h_x2c_s[i] <= h_x2b_s[i];
			end
		end else begin : g_last
			logic unused_x2;
			assign unused_x2 = ^h_x2b_s[i];
		end
	end

	// weight (1 + cos)/2 in Q30, then scaled rate difference
	logic [30:0] w_s;
	logic [31:0] cos_v_s;

	always_ff @(posedge clk) begin
		w_s <= h_nc_s[NH-1]
			? 31'((32'(lrs_pkg::Q30_ONE) - 32'(ht_s[NH-1])) >> 1)
			: 31'((32'(lrs_pkg::Q30_ONE) + 32'(ht_s[NH-1])) >> 1);
		cos_v_s <= 32'((64'(abs_diff) * 64'(w_s) + (64'd1 << 29)) >> 30);
	end

	// align the warmup and step results and the request flags to the cosine
	logic [31:0] warm_quo_d;
	logic [31:0] step_d;
	logic        vld_d;
	logic        warm_d;

	lrs_delay #(.W(32), .N(D_WARM)) u_dly_warm (
		.clk    (clk),
		.arst_n (arst_n),
		.d      (wquo[31:0]),
		.q      (warm_quo_d)
	);

	lrs_delay #(.W(32), .N(D_STEP)) u_dly_step (
		.clk    (clk),
		.arst_n (arst_n),
		.d      (step_s),
		.q      (step_d)
	);

	lrs_delay #(.W(2), .N(LAT_COS)) u_dly_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.d      ({vld_s2, warm_s2}),
		.q      ({vld_d, warm_d})
	);

	// select the phase and clamp to the floor rate
	logic [31:0] rate_c;
	logic [1:0]  phase_c;
	logic        done_q;
	logic [31:0] rate_q;
	logic [1:0]  phase_q;

	always_comb begin
		rate_c  = init_q;
		phase_c = lrs_pkg::PHASE_CONSTANT;
		if (warm_d) begin
			rate_c  = diff_neg ? (floor_q - warm_quo_d) : (floor_q + warm_quo_d);
			phase_c = lrs_pkg::PHASE_WARMUP;
		end else begin
			unique case (kind_q)
				lrs_pkg::KIND_STEP, lrs_pkg::KIND_MULTISTEP: begin
					rate_c  = (step_d < floor_q) ? floor_q : step_d;
					phase_c = lrs_pkg::PHASE_STEP;
				end
				lrs_pkg::KIND_COSINE: begin
					// an initial rate below the floor always clamps to the floor
					rate_c  = diff_neg ? floor_q : (floor_q + cos_v_s);
					phase_c = lrs_pkg::PHASE_COSINE;
				end
				lrs_pkg::KIND_CONSTANT: begin
					rate_c  = diff_neg ? floor_q : init_q;
					phase_c = lrs_pkg::PHASE_CONSTANT;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		rate_q  <= rate_c;
		phase_q <= phase_c;
	end

	assign done          = done_q;
	assign learning_rate = rate_q;
	assign phase         = phase_q;

endmodule
